// File: design/spz_pkg.sv
// Shared types and constants of the Spritz sponge core.
package spz_pkg;
	localparam int unsigned N       = 256;
	localparam int unsigned HALF    = N / 2;
	localparam int unsigned WHIP_R  = 2 * N;
	localparam logic [7:0]  HALF_B  = 8'(HALF);

	typedef enum logic [2:0] {
		OP_REINIT  = 3'd0,
		OP_ABSORB  = 3'd1,
		OP_STOP    = 3'd2,
		OP_SQUEEZE = 3'd3,
		OP_ENCRYPT = 3'd4,
		OP_DECRYPT = 3'd5
	} opcode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ABS_CHK,
		ST_ABS_R1,
		ST_ABS_R2,
		ST_ABS_W1,
		ST_ABS_W2,
		ST_SH_DISP,
		ST_U1,
		ST_U2,
		ST_U3,
		ST_U4,
		ST_U5,
		ST_U6,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_O1,
		ST_O2,
		ST_O3,
		ST_O4
	} state_t;
endpackage

// File: design/spz_req_if.sv
// Input channel: one word carries an opcode and a data byte.
interface spz_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] data_byte;
	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

// Output channel: one word carries a result byte.
interface spz_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	modport source (output valid, output out_byte, input ready);
	modport sink (input valid, input out_byte, output ready);
endinterface

// File: design/spritz_sponge_core.sv
// Spritz sponge core: a sequencer around one 256-byte permutation memory.
//
// Channels: req carries an opcode and a data byte, rsp returns one byte for
// squeeze, encrypt and decrypt words. Reinit, absorb and absorb-stop words
// give no result; opcodes 6 and 7 are taken and ignored.
// The permutation sits in a synchronous memory with one read and one write
// per cycle and registered read data; every step of the sponge is a
// read, modify and write-back sequence through that single port pair.
// An update runs through states U1 to U6 and the output function through O1
// to O4, so a squeeze without pending absorb raises rsp valid from O4.
// An absorbed byte takes two nibble swaps, each through ABS_CHK to ABS_W2.
// req is ready again after the last step of a word, once the output register is free or being read.
// A shuffle (three whips of 512 updates, two crushes of 128 pair checks) runs
// when 128 nibbles have been absorbed, or before the first output after an absorb.
// Reset and reinit restore the identity permutation at once through a row of
// per-entry valid bits, and clear i, j, k, z, a and set w to one.
// The result waits in an output register; a stalled receiver holds it and
// req is not taken until that register can accept the next result.
module spritz_sponge_core (
	input  logic clk,
	input  logic arst_n,
	spz_req_if.sink   req,
	spz_rsp_if.source rsp
);
	import spz_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] op_q;
	logic [7:0] data_q;
	logic [7:0] i_q, j_q, k_q, z_q, a_q, w_q;
	logic       nib_hi_q, shuf_q;
	logic [2:0] phase_q;
	logic [8:0] wcnt_q;
	logic [6:0] v_q;
	logic [7:0] t1_q, t3_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;

	logic [7:0] mem [N];
	logic [N-1:0] vld_q;
	logic       re, we;
	logic [7:0] raddr, waddr, wdata;
	logic [7:0] rdata_s1, raddr_s1;
	logic       rvld_s1;
	logic [7:0] rd;
	logic [3:0] nib;
	logic       accept;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.out_byte = out_byte_q;
	// An entry never written since reinit still holds its own index.
	assign rd  = rvld_s1 ? rdata_s1 : raddr_s1;
	assign nib = nib_hi_q ? data_q[7:4] : data_q[3:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
		raddr_s1 <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (accept && req.opcode == OP_REINIT) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_s1 <= vld_q[raddr];
		end
	end

	always_comb begin
		state_d = state_q;
		re      = 1'b0;
		we      = 1'b0;
		raddr   = '0;
		waddr   = '0;
		wdata   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.opcode) inside
						OP_ABSORB: state_d = ST_ABS_CHK;
						OP_STOP: state_d = (a_q == HALF_B) ? ST_SH_DISP : ST_IDLE;
						OP_SQUEEZE, OP_ENCRYPT, OP_DECRYPT:
							state_d = (a_q != '0) ? ST_SH_DISP : ST_U1;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ABS_CHK: state_d = (a_q == HALF_B) ? ST_SH_DISP : ST_ABS_R1;
			ST_ABS_R1: begin
				re = 1'b1; raddr = a_q; state_d = ST_ABS_R2;
			end
			ST_ABS_R2: begin
				re = 1'b1; raddr = HALF_B + {4'd0, nib}; state_d = ST_ABS_W1;
			end
			ST_ABS_W1: begin
				we = 1'b1; waddr = a_q; wdata = rd; state_d = ST_ABS_W2;
			end
			ST_ABS_W2: begin
				we = 1'b1; waddr = HALF_B + {4'd0, nib}; wdata = t1_q;
				state_d = nib_hi_q ? ST_IDLE : ST_ABS_CHK;
			end
			ST_SH_DISP: begin
				case (phase_q) inside
					3'd0, 3'd2, 3'd4: state_d = ST_U1;
					3'd1, 3'd3: state_d = ST_C1;
					default: begin
						unique case (op_q)
							OP_ABSORB: state_d = ST_ABS_R1;
							OP_STOP: state_d = ST_IDLE;
							default: state_d = ST_U1;
						endcase
					end
				endcase
			end
			ST_U1: begin
				re = 1'b1; raddr = i_q + w_q; state_d = ST_U2;
			end
			ST_U2: begin
				re = 1'b1; raddr = j_q + rd; state_d = ST_U3;
			end
			ST_U3: begin
				re = 1'b1; raddr = k_q + rd; state_d = ST_U4;
			end
			ST_U4: state_d = ST_U5;
			ST_U5: begin
				we = 1'b1; waddr = i_q; wdata = t3_q; state_d = ST_U6;
			end
			ST_U6: begin
				we = 1'b1; waddr = j_q; wdata = t1_q;
				if (!shuf_q) begin
					state_d = ST_O1;
				end else if (wcnt_q == 9'(WHIP_R - 1)) begin
					state_d = ST_SH_DISP;
				end else begin
					state_d = ST_U1;
				end
			end
			ST_C1: begin
				re = 1'b1; raddr = {1'b0, v_q}; state_d = ST_C2;
			end
			ST_C2: begin
				re = 1'b1; raddr = {1'b1, ~v_q}; state_d = ST_C3;
			end
			ST_C3: begin
				if (t1_q > rd) begin
					we = 1'b1; waddr = {1'b0, v_q}; wdata = rd; state_d = ST_C4;
				end else begin
					state_d = (v_q == '1) ? ST_SH_DISP : ST_C1;
				end
			end
			ST_C4: begin
				we = 1'b1; waddr = {1'b1, ~v_q}; wdata = t1_q;
				state_d = (v_q == '1) ? ST_SH_DISP : ST_C1;
			end
			ST_O1: begin
				re = 1'b1; raddr = z_q + k_q; state_d = ST_O2;
			end
			ST_O2: begin
				re = 1'b1; raddr = i_q + rd; state_d = ST_O3;
			end
			ST_O3: begin
				re = 1'b1; raddr = j_q + rd; state_d = ST_O4;
			end
			ST_O4: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q <= '0; j_q <= '0; k_q <= '0; z_q <= '0; a_q <= '0;
			w_q         <= 8'd1;
			nib_hi_q    <= 1'b0;
			shuf_q      <= 1'b0;
			phase_q     <= '0;
			wcnt_q      <= '0;
			v_q         <= '0;
			out_valid_q <= 1'b0;
			op_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= req.opcode;
						nib_hi_q <= 1'b0;
						phase_q  <= '0;
						wcnt_q   <= '0;
						v_q      <= '0;
						case (req.opcode) inside
							OP_REINIT: begin
								i_q <= '0; j_q <= '0; k_q <= '0; z_q <= '0;
								a_q <= '0; w_q <= 8'd1;
							end
							OP_STOP: begin
								if (a_q == HALF_B) begin
									shuf_q <= 1'b1;
								end else begin
									a_q <= a_q + 8'd1;
								end
							end
							OP_SQUEEZE, OP_ENCRYPT, OP_DECRYPT: begin
								shuf_q <= (a_q != '0);
							end
							default: ;
						endcase
					end
				end
				ST_ABS_CHK: begin
					if (a_q == HALF_B) begin
						shuf_q <= 1'b1; phase_q <= '0; wcnt_q <= '0;
					end
				end
				ST_ABS_W2: begin
					a_q      <= a_q + 8'd1;
					nib_hi_q <= 1'b1;
				end
				ST_SH_DISP: begin
					wcnt_q <= '0;
					v_q    <= '0;
					if (phase_q == 3'd5) begin
						shuf_q <= 1'b0;
						a_q    <= (op_q == OP_STOP) ? 8'd1 : 8'd0;
					end
				end
				ST_U1: i_q <= i_q + w_q;
				ST_U3: j_q <= k_q + rd;
				ST_U4: begin
					k_q  <= i_q + k_q + rd;
					t3_q <= rd;
				end
				ST_U6: begin
					if (shuf_q) begin
						wcnt_q <= wcnt_q + 9'd1;
						if (wcnt_q == 9'(WHIP_R - 1)) begin
							w_q     <= w_q + 8'd2;
							phase_q <= phase_q + 3'd1;
						end
					end
				end
				ST_C3: begin
					if (!(t1_q > rd)) begin
						v_q <= v_q + 7'd1;
						if (v_q == '1) phase_q <= phase_q + 3'd1;
					end
				end
				ST_C4: begin
					v_q <= v_q + 7'd1;
					if (v_q == '1) phase_q <= phase_q + 3'd1;
				end
				ST_O4: begin
					z_q         <= rd;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.data_byte;
		end
		if (state_q == ST_ABS_R2 || state_q == ST_U2 || state_q == ST_C2) begin
			t1_q <= rd;
		end
		if (state_q == ST_O4) begin
			unique case (op_q)
				OP_ENCRYPT: out_byte_q <= data_q + rd;
				OP_DECRYPT: out_byte_q <= data_q - rd;
				default: out_byte_q <= rd;
			endcase
		end
	end

	a_w_odd: assert property (@(posedge clk) disable iff (!arst_n) w_q[0])
		else $error("step w lost its odd value");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) a_q <= HALF_B)
		else $error("absorb count went past its limit");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_O4 |-> !out_valid_q || rsp.ready)
		else $error("result overwrote a word not yet taken");
	a_shuf_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !shuf_q)
		else $error("shuffle left pending on return to idle");
endmodule

// File: test/spritz_sponge_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the Spritz sponge core: directed and random opcode words checked against a predictor.
module spritz_sponge_core_tb;
	import spz_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk;
	logic arst_n;

	spz_req_if req ();
	spz_rsp_if rsp ();

	spritz_sponge_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// Predictor state
	logic [7:0] sp_s [256];
	logic [7:0] sp_i, sp_j, sp_k, sp_z, sp_a, sp_w;

	logic [7:0] expected_bytes [$];
	int errors;
	int words_sent;
	int bytes_checked;
	int shuffles_seen;
	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;
	bit timed_out;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void sp_reset();
		for (int v = 0; v < 256; v++) sp_s[v] = 8'(v);
		sp_i = '0;
		sp_j = '0;
		sp_k = '0;
		sp_z = '0;
		sp_a = '0;
		sp_w = 8'd1;
	endfunction

	function automatic void sp_swap(logic [7:0] x, logic [7:0] y);
		logic [7:0] t;
		t = sp_s[x];
		sp_s[x] = sp_s[y];
		sp_s[y] = t;
	endfunction

	function automatic void sp_update();
		sp_i = sp_i + sp_w;
		sp_j = sp_k + sp_s[8'(sp_j + sp_s[sp_i])];
		sp_k = sp_i + sp_k + sp_s[sp_j];
		sp_swap(sp_i, sp_j);
	endfunction

	function automatic void sp_whip();
		for (int r = 0; r < 2 * 256; r++) sp_update();
		sp_w = sp_w + 8'd1;
		if (!sp_w[0]) sp_w = sp_w + 8'd1;
	endfunction

	function automatic void sp_crush();
		for (int v = 0; v < 128; v++) begin
			if (sp_s[v] > sp_s[255 - v]) sp_swap(8'(v), 8'(255 - v));
		end
	endfunction

	function automatic void sp_shuffle();
		sp_whip();
		sp_crush();
		sp_whip();
		sp_crush();
		sp_whip();
		sp_a = '0;
		shuffles_seen++;
	endfunction

	function automatic void sp_absorb_nibble(logic [3:0] x);
		if (sp_a == HALF_B) sp_shuffle();
		sp_swap(sp_a, 8'(128 + x));
		sp_a = sp_a + 8'd1;
	endfunction

	function automatic logic [7:0] sp_drip();
		logic [7:0] p, q;
		if (sp_a > 0) sp_shuffle();
		sp_update();
		p = sp_s[8'(sp_z + sp_k)];
		q = sp_s[8'(sp_i + p)];
		sp_z = sp_s[8'(sp_j + q)];
		return sp_z;
	endfunction

	// Applies one accepted word to the predictor and queues any result byte.
	function automatic void predict_word(logic [2:0] op, logic [7:0] d);
		logic [7:0] z;
		case (op)
			OP_REINIT: sp_reset();
			OP_ABSORB: begin
				sp_absorb_nibble(d[3:0]);
				sp_absorb_nibble(d[7:4]);
			end
			OP_STOP: begin
				if (sp_a == HALF_B) sp_shuffle();
				sp_a = sp_a + 8'd1;
			end
			OP_SQUEEZE: expected_bytes.push_back(sp_drip());
			OP_ENCRYPT: begin
				z = sp_drip();
				expected_bytes.push_back(d + z);
			end
			OP_DECRYPT: begin
				z = sp_drip();
				expected_bytes.push_back(d - z);
			end
			default: ;
		endcase
	endfunction

	// Leaves valid high after the accepting edge; the next driver of valid
	// in the same time step decides what follows.
	task automatic send_word(logic [2:0] op, logic [7:0] d);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			req.opcode <= 3'($urandom);
			req.data_byte <= 8'($urandom);
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.data_byte <= d;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_word(op, d);
		words_sent++;
	endtask

	// Lets the block drain before the next phase.
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_bytes.size() != 0 && !timed_out) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Receiver stall driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_bytes.size() == 0) begin
				$error("out_byte: no result expected, actual %0d", rsp.out_byte);
				errors++;
			end else begin
				if (rsp.out_byte !== expected_bytes[0]) begin
					$error("out_byte: expected %0d, actual %0d", expected_bytes[0],
						rsp.out_byte);
					errors++;
				end
				void'(expected_bytes.pop_front());
				bytes_checked++;
			end
		end
	end

	// Watchdog on cycles without any accepted word or taken result.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				timed_out = 1'b1;
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_word(OP_SQUEEZE, 8'h00);
		send_word(OP_ENCRYPT, 8'hFF);
		send_word(OP_DECRYPT, 8'h00);
		send_word(OP_DECRYPT, 8'hFF);
		send_word(OP_ABSORB, 8'h00);
		send_word(OP_ABSORB, 8'hFF);
		send_word(OP_ABSORB, 8'h5A);
		send_word(OP_STOP, 8'hA5);
		send_word(OP_SQUEEZE, 8'hFF);
		send_word(OP_ENCRYPT, 8'h00);
		send_word(3'd6, 8'h12);
		send_word(3'd7, 8'hED);
		send_word(OP_SQUEEZE, 8'h00);
		send_word(OP_REINIT, 8'hFF);
		send_word(OP_SQUEEZE, 8'h00);
		// Absorb 128 nibbles so the counter-driven shuffle fires on the following stop.
		for (int n = 0; n < 64; n++) send_word(OP_ABSORB, 8'(n * 37));
		send_word(OP_STOP, 8'h00);
		send_word(OP_DECRYPT, 8'h80);
		send_word(OP_REINIT, 8'h00);
		for (int n = 0; n < 128; n++) send_word(OP_STOP, 8'h00);
		send_word(OP_STOP, 8'h00);
		send_word(OP_ENCRYPT, 8'h7F);
	endtask

	task automatic test_random(int count);
		int r;
		logic [2:0] op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			// Long runs of outputs keep shuffles rare so the run stays short.
			if (r < 60) op = 3'($urandom_range(OP_SQUEEZE, OP_DECRYPT));
			else if (r < 80) op = OP_ABSORB;
			else if (r < 88) op = OP_STOP;
			else if (r < 93) op = OP_REINIT;
			else op = 3'($urandom_range(6, 7));
			if (op == OP_ABSORB && $urandom_range(3) == 0) begin
				// A short key: several bytes, then a stop.
				repeat ($urandom_range(2, 8)) send_word(OP_ABSORB, 8'($urandom));
				send_word(OP_STOP, 8'($urandom));
			end else begin
				send_word(op, 8'($urandom));
			end
		end
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		test_random(count);
		wait_drained();
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		bytes_checked = 0;
		shuffles_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_REINIT;
		req.data_byte = '0;
		sp_reset();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		run_phase(0, 0, 170);
		run_phase(75, 0, 170);
		run_phase(0, 75, 170);
		run_phase(8, 8, 170);

		$display("Sent %0d words, checked %0d result bytes, %0d shuffles predicted.",
			words_sent, bytes_checked, shuffles_seen);
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// File: spritz_sponge_core.f
design/spz_pkg.sv
design/spz_req_if.sv
design/spritz_sponge_core.sv
test/spritz_sponge_core_tb.sv
